FILE: sv/rasi_pkg.sv
`timescale 1ns / 1ps
package rasi_pkg;

    localparam int AXES      = 3;
    localparam int DIV_STEPS = 32;
    // input register, one stage per quotient bit
    localparam int DIV_LAT   = DIV_STEPS + 1;
    // divider, lane result register, merge/output register
    localparam int PIPE_LAT  = DIV_LAT + 2;

    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               par;
        logic               pmiss;
        logic signed [31:0] t_lo;
        logic signed [31:0] t_hi;
    } lane_res_t;

endpackage

FILE: sv/rasi_if.sv
`timescale 1ns / 1ps
interface rasi_req_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                    input ready);
    modport sink (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                  box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
                  output ready);
endinterface

interface rasi_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [30:0] distance;

    modport source (output valid, hit, distance, input ready);
    modport sink (input valid, hit, distance, output ready);
endinterface

interface rasi_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] parallel_threshold;

    modport source (output valid, parallel_threshold, input ready);
    modport sink (input valid, parallel_threshold, output ready);
endinterface

FILE: sv/rasi_div.sv
`timescale 1ns / 1ps
module rasi_div
    import rasi_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [32:0] diff,
    input  logic signed [31:0] dir,
    output logic signed [31:0] quot
);

    logic [63:0] rem_reg [DIV_STEPS+1];
    logic [31:0] den_reg [DIV_STEPS+1];
    logic [31:0] q_reg   [DIV_STEPS+1];
    logic        neg_reg [DIV_STEPS+1];
    logic        ovf_reg [DIV_STEPS+1];

    logic [32:0] diff_mag;
    logic [31:0] den_mag;
    logic [63:0] num;
    logic        ovf_next;

    always_comb
    begin
        diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
        den_mag  = dir[31] ? 32'(-dir) : 32'(dir);
        num      = {15'b0, diff_mag, 16'b0};
        ovf_next = num >= {den_mag, 32'b0};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den_mag;
            q_reg[0]   <= '0;
            neg_reg[0] <= diff[32] ^ dir[31];
            ovf_reg[0] <= ovf_next;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= DIV_STEPS; k++)
        begin : g_step
            localparam int B = DIV_STEPS - k;
            logic [63:0] trial;
            logic        take;
            always_comb
            begin
                trial = {32'b0, den_reg[k-1]} << B;
                take  = rem_reg[k-1] >= trial;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? rem_reg[k-1] - trial : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                    q_reg[k]   <= q_reg[k-1] | (take ? (32'd1 << B) : 32'd0);
                    neg_reg[k] <= neg_reg[k-1];
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (neg_reg[DIV_STEPS])
        begin
            if (ovf_reg[DIV_STEPS] || q_reg[DIV_STEPS] > 32'h8000_0000)
                quot = Q_MIN;
            else
                quot = -$signed(q_reg[DIV_STEPS]);
        end
        else
        begin
            if (ovf_reg[DIV_STEPS] || q_reg[DIV_STEPS][31])
                quot = Q_MAX;
            else
                quot = $signed(q_reg[DIV_STEPS]);
        end
    end

endmodule

FILE: sv/rasi_lane.sv
`timescale 1ns / 1ps
module rasi_lane
    import rasi_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        thr,
    input  logic signed [31:0] org,
    input  logic signed [31:0] dir,
    input  logic signed [31:0] bmin,
    input  logic signed [31:0] bmax,
    output lane_res_t          res
);

    logic [31:0]       mag;
    logic              par_in;
    logic              pmiss_in;
    logic [DIV_LAT-1:0] par_reg;
    logic [DIV_LAT-1:0] pmiss_reg;
    logic signed [31:0] q_a;
    logic signed [31:0] q_b;
    lane_res_t         res_reg;

    always_comb
    begin
        mag      = dir[31] ? 32'(-dir) : 32'(dir);
        par_in   = (dir == 32'sd0) || (mag < {16'b0, thr});
        pmiss_in = par_in && (org < bmin || org > bmax);
    end

    rasi_div u_div_a (
        .clk  (clk),
        .en   (en),
        .diff (33'(bmin) - 33'(org)),
        .dir  (dir),
        .quot (q_a)
    );

    rasi_div u_div_b (
        .clk  (clk),
        .en   (en),
        .diff (33'(bmax) - 33'(org)),
        .dir  (dir),
        .quot (q_b)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par_reg       <= {par_reg[DIV_LAT-2:0], par_in};
            pmiss_reg     <= {pmiss_reg[DIV_LAT-2:0], pmiss_in};
            res_reg.par   <= par_reg[DIV_LAT-1];
            res_reg.pmiss <= pmiss_reg[DIV_LAT-1];
            res_reg.t_lo  <= (q_a > q_b) ? q_b : q_a;
            res_reg.t_hi  <= (q_a > q_b) ? q_a : q_b;
        end
    end

    assign res = res_reg;

endmodule

FILE: sv/ray_aabb_slab_intersect.sv
`timescale 1ns / 1ps
// Slab test of a ray against an axis-aligned box, one item per cycle unless stalled. Each
// of the three axis lanes runs two pipelined restoring dividers (one quotient bit per
// stage) ahead of a lane result register and the output register; the pipeline
// stalls as a whole only while the output register holds an untaken result.
module ray_aabb_slab_intersect
    import rasi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rasi_req_if.sink   req,
    rasi_rsp_if.source rsp,
    rasi_cfg_if.sink   cfg
);

    logic [15:0]          thr_reg;
    logic [PIPE_LAT-2:0]  vld_reg;
    logic                 out_vld_reg;
    logic                 hit_reg;
    logic [30:0]          dist_reg;
    logic                 en;
    lane_res_t            lres [AXES];
    logic signed [31:0]   org  [AXES];
    logic signed [31:0]   dir  [AXES];
    logic signed [31:0]   bmin [AXES];
    logic signed [31:0]   bmax [AXES];
    logic signed [31:0]   near_next;
    logic signed [31:0]   far_next;
    logic                 pmiss_next;
    logic                 hit_next;

    assign en        = !out_vld_reg || rsp.ready;
    assign req.ready = en;
    assign cfg.ready = 1'b1;

    assign org  = '{req.origin_x, req.origin_y, req.origin_z};
    assign dir  = '{req.dir_x, req.dir_y, req.dir_z};
    assign bmin = '{req.box_min_x, req.box_min_y, req.box_min_z};
    assign bmax = '{req.box_max_x, req.box_max_y, req.box_max_z};

    genvar a;
    generate
        for (a = 0; a < AXES; a++)
        begin : g_lane
            rasi_lane u_lane (
                .clk  (clk),
                .en   (en),
                .thr  (thr_reg),
                .org  (org[a]),
                .dir  (dir[a]),
                .bmin (bmin[a]),
                .bmax (bmax[a]),
                .res  (lres[a])
            );
        end
    endgenerate

    // merge the lanes
    always_comb
    begin
        near_next  = 32'sd0;
        far_next   = Q_MAX;
        pmiss_next = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            pmiss_next = pmiss_next | lres[i].pmiss;
            if (!lres[i].par && lres[i].t_lo > near_next)
                near_next = lres[i].t_lo;
            if (!lres[i].par && lres[i].t_hi < far_next)
                far_next = lres[i].t_hi;
        end
        hit_next = !pmiss_next && (near_next <= far_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg     <= 16'd1;
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                thr_reg <= cfg.parallel_threshold;
            if (en)
            begin
                vld_reg     <= {vld_reg[PIPE_LAT-3:0], req.valid};
                out_vld_reg <= vld_reg[PIPE_LAT-2];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            dist_reg <= hit_next ? near_next[30:0] : 31'd0;
        end
    end

    assign rsp.valid    = out_vld_reg;
    assign rsp.hit      = hit_reg;
    assign rsp.distance = dist_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.hit |-> rsp.distance == 31'd0)
        else $error("miss with nonzero distance");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
        else $error("input ready does not follow output stall");

    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid |=> thr_reg == $past(cfg.parallel_threshold))
        else $error("threshold not written");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule
